[hw/rtl/spwm_pkg.sv]
package spwm_pkg;

   localparam logic [2:0] OP_READ  = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_TICK  = 3'd2;
   localparam logic [2:0] OP_EVENT = 3'd3;
   localparam logic [2:0] OP_ACK   = 3'd4;

   localparam logic [2:0] SRC_NONE = 3'd5;

   localparam logic [7:0] LUPD_BIT = 8'h10;
   localparam logic [7:0] DIR_BIT  = 8'h08;
   localparam logic [7:0] CTRLE_RD_MASK = 8'h18;

   localparam logic [2:0] CMD_UPDATE  = 3'd1;
   localparam logic [2:0] CMD_RESET   = 3'd2;
   localparam logic [2:0] CMD_RESTART = 3'd3;

   localparam logic [5:0] R_CTRLA    = 6'h00;
   localparam logic [5:0] R_CTRLB    = 6'h01;
   localparam logic [5:0] R_CTRLC    = 6'h02;
   localparam logic [5:0] R_CTRLD    = 6'h03;
   localparam logic [5:0] R_CTRLECLR = 6'h04;
   localparam logic [5:0] R_CTRLESET = 6'h05;
   localparam logic [5:0] R_CTRLFCLR = 6'h06;
   localparam logic [5:0] R_CTRLFSET = 6'h07;
   localparam logic [5:0] R_EVCTRL   = 6'h09;
   localparam logic [5:0] R_INTCTRL  = 6'h0A;
   localparam logic [5:0] R_INTFLAGS = 6'h0B;
   localparam logic [5:0] R_DBGCTRL  = 6'h0E;
   localparam logic [5:0] R_TEMP     = 6'h0F;
   localparam logic [5:0] R_CNT      = 6'h20;
   localparam logic [5:0] R_PER      = 6'h26;
   localparam logic [5:0] R_CMP      = 6'h28;
   localparam logic [5:0] R_PERBUF   = 6'h36;
   localparam logic [5:0] R_CMPBUF   = 6'h38;

   function automatic logic [9:0] divider_limit(input logic [2:0] sel);
      logic [9:0] r;
      unique case (sel)
         3'd0: r = 10'd0;
         3'd1: r = 10'd1;
         3'd2: r = 10'd3;
         3'd3: r = 10'd7;
         3'd4: r = 10'd15;
         3'd5: r = 10'd63;
         3'd6: r = 10'd255;
         default: r = 10'd1023;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic [2:0] op;
      logic [5:0] reg_offset;
      logic [7:0] write_data;
      logic       event_level;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_pending;
      logic [2:0] irq_source;
      logic       ack_taken;
      logic [5:0] wave_levels;
      logic [5:0] wave_enables;
      logic       overflow_event;
      logic [2:0] compare_events;
   } rsp_type;

endpackage

[hw/rtl/spwm_req_if.sv]
interface spwm_req_if import spwm_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/spwm_rsp_if.sv]
interface spwm_rsp_if import spwm_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/spwm_core.sv]
module spwm_core import spwm_pkg::*; #(
   parameter int COMPARE_CHANNELS = 3
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   output rsp_type rsp
);
   localparam int NCH = COMPARE_CHANNELS;

   logic [7:0]  ctrl_ff [8];
   logic [7:0]  ctrl_in [8];
   logic [7:0]  flags_ff, flags_in, temp_ff, temp_in, ctle_ff, ctle_in, bv_ff, bv_in;
   logic [15:0] cnt_ff, cnt_in, per_ff, per_in, perb_ff, perb_in;
   logic [15:0] cmp_ff [3];
   logic [15:0] cmp_in [3];
   logic [15:0] cmpb_ff [3];
   logic [15:0] cmpb_in [3];
   logic        up_ff, up_in, lev_ff, lev_in, tog_ff, tog_in;
   logic [9:0]  pre_ff, pre_in;

   always_comb begin
      logic [7:0] rd, m, ft, mk;
      logic ack, ovf, split, upd, bottom, hit, odd, doit, rowsplit;
      logic [2:0] cp, mode, src, cmd;
      logic [5:0] base, wl, en;
      logic [7:0] lo, hi;
      logic [1:0] ch;
      rd = 8'd0; ack = 1'b0; ovf = 1'b0; cp = 3'd0;
      upd = 1'b0; bottom = 1'b0; doit = 1'b0; rowsplit = 1'b0;
      cmd = 3'd0; src = SRC_NONE; mk = 8'd0; ch = 2'd0; hit = 1'b0;
      lo = 8'd0; hi = 8'd0; m = 8'd0;
      for (int i = 0; i < 8; i++) ctrl_in[i] = ctrl_ff[i];
      flags_in = flags_ff; temp_in = temp_ff; ctle_in = ctle_ff; bv_in = bv_ff;
      cnt_in = cnt_ff; per_in = per_ff; perb_in = perb_ff;
      for (int i = 0; i < 3; i++) begin
         cmp_in[i] = cmp_ff[i]; cmpb_in[i] = cmpb_ff[i];
      end
      up_in = up_ff; lev_in = lev_ff; tog_in = tog_ff; pre_in = pre_ff;
      split = ctrl_ff[3][0];
      mode = ctrl_ff[1][2:0];
      base = {req.reg_offset[5:1], 1'b0};
      odd = req.reg_offset[0];

      unique case (req.op)
         OP_READ: begin
            unique case (req.reg_offset)
               R_CTRLA, R_CTRLB, R_CTRLC, R_CTRLD: rd = ctrl_ff[req.reg_offset[1:0]];
               R_CTRLECLR, R_CTRLESET: rd = ctle_ff & CTRLE_RD_MASK;
               R_CTRLFCLR, R_CTRLFSET: rd = ctrl_ff[7];
               R_EVCTRL:   rd = ctrl_ff[4];
               R_INTCTRL:  rd = ctrl_ff[5];
               R_INTFLAGS: rd = flags_ff;
               R_DBGCTRL:  rd = ctrl_ff[6];
               R_TEMP:     rd = temp_ff;
               default: begin
                  logic [15:0] v;
                  logic found, buf_r, pch;
                  found = 1'b1; buf_r = 1'b0; pch = 1'b0; v = 16'd0;
                  if (base == R_CNT) v = cnt_ff;
                  else if (base == R_PER) v = per_ff;
                  else if (base == R_PERBUF) begin v = perb_ff; buf_r = 1'b1; pch = 1'b1; end
                  else if (base >= R_CMP && base <= R_CMP + 6'd4) begin
                     ch = 2'(base[2:1] - R_CMP[2:1]);
                     found = 32'(ch) < NCH;
                     v = cmp_ff[ch];
                  end else if (base >= R_CMPBUF && base <= R_CMPBUF + 6'd4) begin
                     ch = 2'(base[2:1] - R_CMPBUF[2:1]);
                     found = 32'(ch) < NCH;
                     v = cmpb_ff[ch]; buf_r = 1'b1;
                  end else found = 1'b0;
                  if (found) begin
                     if (split) begin
                        if (!buf_r) rd = odd ? v[15:8] : v[7:0];
                        else if (odd) rd = 8'd0;
                        else if (pch) rd = {4'd0, per_ff[11:8]};
                        else rd = cmp_ff[ch][15:8];
                     end else if (odd) rd = temp_ff;
                     else begin
                        temp_in = v[15:8]; rd = v[7:0];
                     end
                  end
               end
            endcase
         end
         OP_WRITE: begin
            unique case (req.reg_offset)
               R_CTRLA: begin ctrl_in[0] = req.write_data; pre_in = 10'd0; end
               R_CTRLB, R_CTRLC, R_CTRLD: ctrl_in[req.reg_offset[1:0]] = req.write_data;
               R_CTRLECLR: begin
                  ctle_in = ctle_ff & ~(req.write_data & (DIR_BIT | LUPD_BIT));
                  cmd = req.write_data[2:0];
               end
               R_CTRLESET: begin
                  ctle_in = ctle_ff | (req.write_data & (DIR_BIT | LUPD_BIT));
                  cmd = req.write_data[2:0];
               end
               R_CTRLFCLR: ctrl_in[7] = ctrl_ff[7] & ~req.write_data;
               R_CTRLFSET: ctrl_in[7] = ctrl_ff[7] | req.write_data;
               R_EVCTRL:   ctrl_in[4] = req.write_data;
               R_INTCTRL:  ctrl_in[5] = req.write_data;
               R_INTFLAGS: flags_in = flags_ff & ~req.write_data;
               R_DBGCTRL:  ctrl_in[6] = req.write_data;
               R_TEMP:     temp_in = req.write_data;
               default: begin
                  logic [1:0] kind; // 0 cnt 1 per 2 cmp 3 none
                  logic buf_w;
                  logic [15:0] nv;
                  kind = 2'd3; buf_w = 1'b0;
                  nv = {req.write_data, temp_ff};
                  if (base == R_CNT) kind = 2'd0;
                  else if (base == R_PER) kind = 2'd1;
                  else if (base == R_PERBUF) begin kind = 2'd1; buf_w = 1'b1; end
                  else if (base >= R_CMP && base <= R_CMP + 6'd4) begin
                     ch = 2'(base[2:1] - R_CMP[2:1]);
                     if (32'(ch) < NCH) kind = 2'd2;
                  end else if (base >= R_CMPBUF && base <= R_CMPBUF + 6'd4) begin
                     ch = 2'(base[2:1] - R_CMPBUF[2:1]);
                     if (32'(ch) < NCH) begin kind = 2'd2; buf_w = 1'b1; end
                  end
                  if (kind != 2'd3) begin
                     if (split) begin
                        if (!buf_w) begin
                           unique case (kind)
                              2'd0: if (odd) cnt_in[15:8] = req.write_data;
                                    else cnt_in[7:0] = req.write_data;
                              2'd1: if (odd) per_in[15:8] = req.write_data;
                                    else per_in[7:0] = req.write_data;
                              default: if (odd) cmp_in[ch][15:8] = req.write_data;
                                       else cmp_in[ch][7:0] = req.write_data;
                           endcase
                        end else if (!odd) begin
                           if (kind == 2'd1) per_in[11:8] = req.write_data[3:0];
                           else cmp_in[ch][15:8] = req.write_data;
                        end
                     end else if (!odd) temp_in = req.write_data;
                     else begin
                        unique case ({buf_w, kind})
                           3'b000: cnt_in = nv;
                           3'b001: per_in = nv;
                           3'b010: cmp_in[ch] = nv;
                           3'b101: perb_in = nv;
                           default: cmpb_in[ch] = nv;
                        endcase
                        if (buf_w) begin
                           mk = (kind == 2'd1) ? 8'h01 : 8'(8'h02 << ch);
                           bv_in = bv_ff | mk;
                           ctrl_in[7] = ctrl_ff[7] | mk;
                        end
                     end
                  end
               end
            endcase
         end
         OP_TICK: if (ctrl_ff[0][0]) begin
            if (pre_ff >= divider_limit(ctrl_ff[0][3:1])) begin
               pre_in = 10'd0;
               doit = 1'b1;
               rowsplit = split;
            end else pre_in = pre_ff + 10'd1;
         end
         OP_EVENT: begin
            lev_in = req.event_level;
            if (req.event_level && !lev_ff && ctrl_ff[0][0]) doit = 1'b1;
         end
         OP_ACK: begin
            m = flags_ff & ctrl_ff[5];
            if (ctrl_ff[0][0]) begin
               if (m[0]) begin flags_in = flags_ff & ~8'h01; ack = 1'b1; end
               else if (split && m[1]) begin flags_in = flags_ff & ~8'h02; ack = 1'b1; end
               else if (m[4]) begin flags_in = flags_ff & ~8'h10; ack = 1'b1; end
               else if (m[5]) begin flags_in = flags_ff & ~8'h20; ack = 1'b1; end
               else if (m[6]) begin flags_in = flags_ff & ~8'h40; ack = 1'b1; end
            end
         end
         default: ;
      endcase

      // counting step (only from tick/event, which touch none of the above)
      if (doit && rowsplit) begin
         lo = cnt_ff[7:0]; hi = cnt_ff[15:8];
         if (lo >= per_ff[7:0]) begin
            lo = 8'd0;
            flags_in[0] = 1'b1;
            if (!(ctle_ff[4])) begin
               if (bv_ff[0]) begin per_in[7:0] = perb_ff[7:0]; bv_in[0] = 1'b0; end
               for (int c = 0; c < NCH; c++)
                  if (bv_ff[c+1]) begin
                     cmp_in[c][7:0] = cmpb_ff[c][7:0]; bv_in[c+1] = 1'b0;
                  end
            end
         end else lo = lo + 8'd1;
         if (hi >= per_ff[15:8]) begin hi = 8'd0; flags_in[1] = 1'b1; end
         else hi = hi + 8'd1;
         cnt_in = {hi, lo};
      end else if (doit) begin
         if (mode == 3'd1) begin
            if (cnt_ff >= cmp_ff[0]) begin
               cnt_in = 16'd0; upd = 1'b1; tog_in = ~tog_ff;
            end else cnt_in = cnt_ff + 16'd1;
         end else if (mode >= 3'd5) begin
            if (up_ff) begin
               if (cnt_ff >= per_ff) begin
                  up_in = 1'b0; upd = 1'b1;
                  if (cnt_ff != 16'd0) cnt_in = cnt_ff - 16'd1;
               end else cnt_in = cnt_ff + 16'd1;
            end else if (cnt_ff == 16'd0) begin
               up_in = 1'b1; bottom = 1'b1; upd = 1'b1; cnt_in = 16'd1;
            end else cnt_in = cnt_ff - 16'd1;
         end else begin
            if (cnt_ff >= per_ff) begin
               cnt_in = 16'd0; upd = 1'b1; bottom = 1'b1;
            end else cnt_in = cnt_ff + 16'd1;
         end
      end

      if (doit) begin
         // compare matches on the new count against cmp values before apply
         for (int c = 0; c < NCH; c++) begin
            hit = split ? (cnt_in[7:0] == cmp_in[c][7:0]) : (cnt_in == cmp_in[c]);
            if (hit) begin flags_in[4+c] = 1'b1; cp[c] = 1'b1; end
         end
         if (split && cnt_in[15:8] == cmp_in[0][15:8]) flags_in[7] = 1'b1;
         if (bottom) begin flags_in[0] = 1'b1; ovf = 1'b1; end
      end

      // buffer apply: normal-mode update point or command
      if ((doit && !rowsplit && upd) || cmd == CMD_UPDATE || cmd == CMD_RESTART) begin
         if (cmd == CMD_RESTART) begin
            cnt_in = 16'd0; up_in = 1'b1; flags_in = 8'd0;
         end
         if (!ctle_in[4]) begin
            if (bv_in[0]) begin per_in = perb_in; bv_in[0] = 1'b0; ctrl_in[7][0] = 1'b0; end
            for (int c = 0; c < NCH; c++)
               if (bv_in[c+1]) begin
                  cmp_in[c] = cmpb_in[c]; bv_in[c+1] = 1'b0; ctrl_in[7][c+1] = 1'b0;
               end
         end
      end
      if (cmd == CMD_RESET) begin
         for (int i = 0; i < 8; i++) ctrl_in[i] = 8'd0;
         flags_in = 8'd0; temp_in = 8'd0; ctle_in = 8'd0; bv_in = 8'd0;
         cnt_in = 16'd0; per_in = 16'hFFFF; perb_in = 16'hFFFF;
         for (int i = 0; i < 3; i++) begin cmp_in[i] = 16'd0; cmpb_in[i] = 16'd0; end
         up_in = 1'b1; lev_in = 1'b0; pre_in = 10'd0; tog_in = 1'b0;
      end

      // outputs from post-item state
      ft = flags_in & ctrl_in[5];
      if (!ctrl_in[0][0]) src = SRC_NONE;
      else if (ft[0]) src = 3'd0;
      else if (ctrl_in[3][0] && ft[1]) src = 3'd1;
      else if (ft[4]) src = 3'd2;
      else if (ft[5]) src = 3'd3;
      else if (ft[6]) src = 3'd4;
      else src = SRC_NONE;
      wl = 6'd0;
      if (ctrl_in[0][0]) begin
         for (int c = 0; c < NCH; c++) begin
            if (ctrl_in[3][0]) begin
               if (cnt_in[7:0] < cmp_in[c][7:0]) wl[c] = 1'b1;
               if (cnt_in[15:8] < cmp_in[c][15:8]) wl[c+3] = 1'b1;
            end else if (c == 0 && ctrl_in[1][2:0] == 3'd1) wl[0] = tog_in;
            else if (cnt_in < cmp_in[c]) wl[c] = 1'b1;
         end
      end
      en = {3'd0, ctrl_in[1][6:4]};
      if (ctrl_in[3][0]) en[5:3] = ctrl_in[2][2:0];

      rsp.read_data = rd;
      rsp.irq_pending = (src != SRC_NONE);
      rsp.irq_source = src;
      rsp.ack_taken = ack;
      rsp.wave_levels = wl;
      rsp.wave_enables = en;
      rsp.overflow_event = ovf;
      rsp.compare_events = cp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) ctrl_ff[i] <= 8'd0;
         flags_ff <= 8'd0; temp_ff <= 8'd0; ctle_ff <= 8'd0; bv_ff <= 8'd0;
         cnt_ff <= 16'd0; per_ff <= 16'hFFFF; perb_ff <= 16'hFFFF;
         for (int i = 0; i < 3; i++) begin cmp_ff[i] <= 16'd0; cmpb_ff[i] <= 16'd0; end
         up_ff <= 1'b1; lev_ff <= 1'b0; pre_ff <= 10'd0; tog_ff <= 1'b0;
      end else if (step) begin
         for (int i = 0; i < 8; i++) ctrl_ff[i] <= ctrl_in[i];
         flags_ff <= flags_in; temp_ff <= temp_in; ctle_ff <= ctle_in; bv_ff <= bv_in;
         cnt_ff <= cnt_in; per_ff <= per_in; perb_ff <= perb_in;
         for (int i = 0; i < 3; i++) begin cmp_ff[i] <= cmp_in[i]; cmpb_ff[i] <= cmpb_in[i]; end
         up_ff <= up_in; lev_ff <= lev_in; pre_ff <= pre_in; tog_ff <= tog_in;
      end
   end
endmodule

[hw/rtl/sixteen_bit_pwm_timer_split_mode_unit.sv]
// channel  dir  payload
// req      in   op, reg_offset, write_data, event_level
// rsp      out  read_data, irq flags/source, ack_taken, wave, events
// One transaction per cycle while the result register can drain.
// The input register loads at acceptance; the timer state and the result register
// update together when the held request fires, once the result register is free.
// The result register holds until taken, and req stays ready while it can drain.
// Reset is synchronous and returns the timer to its power-on state.
module sixteen_bit_pwm_timer_split_mode_unit import spwm_pkg::*; #(
   parameter int COMPARE_CHANNELS = 3
) (
   input logic       clock,
   input logic       reset,
   spwm_req_if.sink  req,
   spwm_rsp_if.source rsp
);
   logic    in_valid_ff;
   req_type in_ff;
   logic    out_valid_ff;
   rsp_type out_ff, core_rsp;
   logic    fire, out_free;

   assign out_free = !out_valid_ff || rsp.ready;
   assign fire = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   spwm_core #(.COMPARE_CHANNELS(COMPARE_CHANNELS)) u_core (
      .clock(clock), .reset(reset), .step(fire), .req(in_ff), .rsp(core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) in_valid_ff <= req.valid;
         if (out_free) out_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) in_ff <= req.data;
      if (fire) out_ff <= core_rsp;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;
endmodule
